/* hdl/zvd_pkg.sv */
// Shared types and constants for the zigzag varint stream decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package zvd_pkg;

  // Configuration register indexes
  localparam logic CFG_VALUE_KIND  = 1'b0;
  localparam logic CFG_INDEX_LIMIT = 1'b1;

  // value_kind codes (code 3 behaves as long)
  localparam logic [1:0] KIND_LONG  = 2'd0;
  localparam logic [1:0] KIND_INT   = 2'd1;
  localparam logic [1:0] KIND_INDEX = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // Index of the tenth (last legal) 7-bit group
  localparam logic [3:0] LAST_GROUP = 4'd9;

  localparam logic [1:0]  KIND_RESET  = KIND_LONG;
  localparam logic [31:0] LIMIT_RESET = 32'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
    logic [3:0]         byte_count;
  } out_item_t;

  // Occupancy of the two output stages
  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

`default_nettype wire

/* hdl/zvd_accum.sv */
// Accumulator and group counter, with the single-pass decode of one byte.
// Depends on zvd_pkg.
`default_nettype none

module zvd_accum (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire zvd_pkg::in_item_t item,
  input  wire logic [1:0]        value_kind,
  input  wire logic [31:0]       index_limit,
  output logic                   res_valid,
  output zvd_pkg::out_item_t     res_item
);
  import zvd_pkg::*;

  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  gc_r, gc_nxt;
  logic [3:0]  gc_c;
  logic [5:0]  shamt;
  logic [63:0] acc_new;
  logic [63:0] zz;
  logic        ovf;
  logic        in_range;

  always_comb begin
    gc_c    = (gc_r > LAST_GROUP) ? LAST_GROUP : gc_r;
    shamt   = 6'({2'b00, gc_c} * 6'd7);
    acc_new = acc_r | ({57'd0, item.data_byte[6:0]} << shamt);
    ovf     = (gc_c == LAST_GROUP) && ((item.data_byte & 8'hfe) != 8'h00);
    zz      = {1'b0, acc_new[63:1]} ^ {64{acc_new[0]}};

    unique case (value_kind)
      KIND_INT:   in_range = (zz[63:31] == 33'd0) || (zz[63:31] == {33{1'b1}});
      KIND_INDEX: in_range = (zz[63:32] == 32'd0) && (zz[31:0] < index_limit);
      default:    in_range = 1'b1;
    endcase

    res_valid           = 1'b1;
    res_item.value      = 64'sd0;
    res_item.byte_count = gc_c + 4'd1;
    acc_nxt             = 64'd0;
    gc_nxt              = 4'd0;

    if (ovf) begin
      res_item.status = ST_OVERFLOW;
    end else if (item.data_byte[7]) begin
      res_item.status = ST_TRUNCATED;
      if (!item.buffer_end) begin
        // continuation: keep gathering, no result
        res_valid = 1'b0;
        acc_nxt   = acc_new;
        gc_nxt    = gc_c + 4'd1;
      end
    end else if (!in_range) begin
      res_item.status = ST_RANGE;
    end else begin
      res_item.status = ST_OK;
      res_item.value  = $signed(zz);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 64'd0;
      gc_r  <= 4'd0;
    end else if (accept) begin
      acc_r <= acc_nxt;
      gc_r  <= gc_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/zvd_out_buf.sv */
// Output register plus skid stage for result items.
// Depends on zvd_pkg.
`default_nettype none

module zvd_out_buf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire zvd_pkg::out_item_t push_item,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output zvd_pkg::out_item_t      out_data,
  output zvd_pkg::buf_status_t    status
);
  import zvd_pkg::*;

  logic      main_valid_r;
  logic      skid_valid_r;
  out_item_t main_r;
  out_item_t skid_r;
  logic      pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign status    = '{main_valid: main_valid_r, skid_valid: skid_valid_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Payload: move skid forward on pop, otherwise land new item in a free stage
  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      main_r <= skid_r;
    end else if (push && (pop || !main_valid_r)) begin
      main_r <= push_item;
    end else if (push) begin
      skid_r <= push_item;
    end
  end

endmodule

`default_nettype wire

/* hdl/zigzag_varint_stream_decoder_core.sv */
// Top level of the zigzag varint stream decoder: configuration registers,
// byte accumulator (zvd_accum) and output buffer (zvd_out_buf). Uses zvd_pkg.
`default_nettype none

// The decoder takes one byte of a varint stream per item and may accept a
// new item in every cycle. Each byte is folded into a 64-bit accumulator in
// the cycle it is accepted; when a byte with bit 7 clear arrives, the value is
// zigzag-decoded, range-checked against value_kind/index_limit and written to
// the output register, or to the skid stage if the output register keeps
// its result. Continuation bytes give no result item. Overflow (a tenth byte
// with any bit above bit 0 set) and truncation (buffer_end on a continuation
// byte) give an error result with value 0, and the next byte starts a new
// value. Sustained rate is one item per clock while in_stall is low; the
// only source of in_stall is the two-entry output buffer (output register
// plus skid stage), raising in_stall once both entries hold untaken results.
// Write configuration only while the block is idle.
module zigzag_varint_stream_decoder_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire zvd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output zvd_pkg::out_item_t      out_data
);
  import zvd_pkg::*;

  logic [1:0]  value_kind_r;
  logic [31:0] index_limit_r;
  logic        in_accept;
  logic        res_valid;
  out_item_t   res_item;
  logic        buf_full;
  buf_status_t buf_status;

  // Configuration: hold values until the next write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_kind_r  <= KIND_RESET;
      index_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VALUE_KIND:  value_kind_r  <= cfg_data[1:0];
        CFG_INDEX_LIMIT: index_limit_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Stall only while the skid stage is occupied
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !in_stall;

  zvd_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .item        (in_data),
    .value_kind  (value_kind_r),
    .index_limit (index_limit_r),
    .res_valid   (res_valid),
    .res_item    (res_item)
  );

  zvd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && res_valid),
    .push_item (res_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (buf_status)
  );

`ifndef SYNTHESIS
  // Skid stage fills only behind an occupied output register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    buf_status.skid_valid |-> buf_status.main_valid)
    else $error("skid stage valid with empty output register");

  // Any error result carries a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |-> (out_data.value == 64'sd0))
    else $error("error result with non-zero value");

  // Byte count of a result lies in 1..10
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.byte_count != 4'd0) && (out_data.byte_count <= 4'd10)))
    else $error("byte count out of range");

  // A result accepted into a full output register lands in the skid stage
  a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && res_valid && out_valid && out_stall) |=> buf_status.skid_valid)
    else $error("result lost while output stalled");
`endif

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for zigzag_varint_stream_decoder_core.
// Holds a scoreboard class that predicts every decoded value from the accepted
// bytes; depends only on zvd_pkg and the core itself.
`timescale 1ns / 100ps

module tb;
  import zvd_pkg::*;

  localparam int          CLK_HALF   = 6;
  localparam int          RUN_LIMIT  = 800000;
  localparam int          HOLD_LEN   = 400;
  localparam int          SETTLE     = 4;
  localparam logic [1:0]  KIND_SPARE = 2'd3;   // unused code, decodes as long

  // Predicts the decoder: folds each accepted byte into its own accumulator
  // and queues the result item that the byte completes, if any.
  class varint_scoreboard;
    logic [63:0] acc;
    logic [3:0]  groups;
    logic [1:0]  kind;
    logic [31:0] limit;
    out_item_t   expected_values[$];
    int          errors;

    function new();
      acc    = '0;
      groups = '0;
      kind   = KIND_RESET;
      limit  = LIMIT_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] data);
      if (idx == CFG_VALUE_KIND) kind = data[1:0];
      else limit = data;
    endfunction

    function void finish_value(out_item_t res);
      expected_values.push_back(res);
      acc    = '0;
      groups = '0;
    endfunction

    function void take_byte(in_item_t it);
      logic [3:0]  grp;
      logic [63:0] zz;
      logic        fits;
      out_item_t   res;
      grp            = (groups > LAST_GROUP) ? LAST_GROUP : groups;
      res.value      = '0;
      res.status     = ST_OK;
      res.byte_count = grp + 4'd1;
      // Tenth byte may carry only bit 0; this beats truncation too
      if (grp == LAST_GROUP && it.data_byte[7:1] != 7'd0) begin
        res.status = ST_OVERFLOW;
        finish_value(res);
        return;
      end
      acc = acc | (64'(it.data_byte[6:0]) << (7 * grp));
      if (it.data_byte[7]) begin
        if (it.buffer_end) begin
          res.status = ST_TRUNCATED;
          finish_value(res);
        end else begin
          groups = grp + 4'd1;
        end
        return;
      end
      zz = (acc >> 1) ^ {64{acc[0]}};
      case (kind)
        KIND_INT:   fits = (zz + 64'h8000_0000) < 64'h1_0000_0000;
        KIND_INDEX: fits = !zz[63] && (zz < {32'd0, limit});
        default:    fits = 1'b1;
      endcase
      if (fits) res.value = zz;
      else res.status = ST_RANGE;
      finish_value(res);
    endfunction

    function void check_value(out_item_t got);
      out_item_t want;
      if (expected_values.size() == 0) begin
        $error("unexpected result: value %0d status %0d byte_count %0d",
               got.value, got.status, got.byte_count);
        errors++;
        return;
      end
      want = expected_values.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, got.value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.byte_count !== want.byte_count) begin
        $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  varint_scoreboard board = new();

  int bytes_sent = 0;
  int cycles     = 0;
  bit tx_quiet   = 1'b0;   // sender offers back to back
  bit rx_quiet   = 1'b0;   // receiver never stalls
  bit hold_req   = 1'b0;   // ask the receiver for one long hold-off

  zigzag_varint_stream_decoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: give up well beyond the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("** zigzag_varint_stream_decoder_core: FAILED **");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge; check the result item before
  // noting the byte, since a byte's result is registered and never shows up in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_value(out_data);
      if (in_valid && !in_stall) board.take_byte(in_data);
    end
  end

  // Receiver: runs of stall and no stall of random length, mostly short.
  // A hold request is picked up at the next falling edge.
  initial begin : receiver
    logic stall_val;
    int   run_len;
    int   pick;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_val = 1'b1;
        run_len   = HOLD_LEN;
      end else if (rx_quiet) begin
        stall_val = 1'b0;
        run_len   = 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          stall_val = 1'b0;
          run_len   = $urandom_range(1, 8);
        end else if (pick < 95) begin
          stall_val = 1'b1;
          run_len   = $urandom_range(1, 4);
        end else begin
          stall_val = 1'b1;
          run_len   = $urandom_range(20, 60);
        end
      end
      out_stall <= stall_val;
      repeat (run_len) begin
        @(negedge clk);
        if (hold_req && run_len != HOLD_LEN) break;
      end
    end
  end

  // Offer one byte, possibly after a gap, and hold it until accepted.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int       gap;
    in_item_t item;
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.data_byte  = b;
    item.buffer_end = last;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted item has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.expected_values.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Encode a zigzag word as a varint, padded with empty groups up to min_len
  task automatic send_varint(input logic [63:0] zz, input int min_len, input logic last);
    int         len;
    logic [6:0] grp;
    len = 1;
    while (len < 10 && (zz >> (7 * len)) != 64'd0) len++;
    if (min_len > len) len = (min_len > 10) ? 10 : min_len;
    for (int i = 0; i < len; i++) begin
      grp = 7'(zz >> (7 * i));
      if (i < len - 1) send_byte({1'b1, grp}, 1'b0);
      else send_byte({1'b0, grp}, last);
    end
  endtask

  // Signed value, biased towards widths, range edges and the index limit
  function automatic logic [63:0] pick_value(input logic [31:0] lim);
    logic [63:0] v;
    int          w;
    int          d;
    d = $urandom_range(0, 4) - 2;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        w = $urandom_range(0, 64);
        v = {$urandom, $urandom};
        if (w < 64) v = v & ((64'd1 << w) - 64'd1);
        if ($urandom_range(0, 1) == 1) v = ~v;
      end
      3, 4: begin
        case ($urandom_range(0, 2))
          0:       v = 64'h0000_0000_7FFF_FFFF;
          1:       v = 64'hFFFF_FFFF_8000_0000;
          default: v = 64'd0;
        endcase
        v = v + 64'(d);
      end
      5, 6:    v = {32'd0, lim} + 64'(d);
      7:       v = {$urandom, $urandom};
      8: begin
        case ($urandom_range(0, 3))
          0:       v = 64'h7FFF_FFFF_FFFF_FFFF;
          1:       v = 64'h8000_0000_0000_0000;
          2:       v = 64'd0;
          default: v = '1;
        endcase
      end
      default: begin
        v = 64'($urandom_range(0, 300));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // One random stream fragment: mostly well-formed values, the rest truncated
  // values, overflowing values and loose bytes
  task automatic send_random_sequence();
    logic [63:0] v;
    int          pick;
    int          k;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      v = pick_value(board.limit);
      send_varint({v[62:0], 1'b0} ^ {64{v[63]}},
                  ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 1,
                  $urandom_range(0, 3) == 0);
    end else if (pick < 80) begin
      k = $urandom_range(1, 9);
      for (int i = 0; i < k; i++) send_byte({1'b1, 7'($urandom)}, i == k - 1);
    end else if (pick < 88) begin
      for (int i = 0; i < 9; i++) send_byte({1'b1, 7'($urandom)}, 1'b0);
      send_byte(8'($urandom_range(2, 255)), $urandom_range(0, 1));
    end else if (pick < 93) begin
      send_varint({$urandom, $urandom}, 10, $urandom_range(0, 1));
    end else begin
      send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic run_phase(input logic [1:0] kind, input logic [31:0] lim, input int n_bytes,
                           input bit quiet, input bit squeeze);
    int stop_at;
    drain_results();
    write_reg(CFG_VALUE_KIND, {30'd0, kind});
    write_reg(CFG_INDEX_LIMIT, lim);
    rx_quiet = quiet;
    tx_quiet = quiet;
    stop_at  = bytes_sent + n_bytes;
    // Hold the receiver off while bytes keep coming, so the output
    // buffer fills and the input side stalls
    if (squeeze) begin
      hold_req = 1'b1;
      tx_quiet = 1'b1;
      while (bytes_sent < stop_at - n_bytes / 2) send_random_sequence();
      tx_quiet = quiet;
    end
    while (bytes_sent < stop_at) send_random_sequence();
    // Close any open value so the next register write finds the block idle
    if (board.groups != 4'd0) send_byte(8'h00, 1'b0);
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
  endtask

  initial begin : stimulus
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset settings (long, limit 1)
    send_byte(8'h00, 1'b0);                       // zero
    send_byte(8'h01, 1'b0);                       // minus one
    send_byte(8'h7f, 1'b1);                       // buffer end on a final byte
    send_byte(8'h80, 1'b1);                       // truncated after one byte
    for (int i = 0; i < 9; i++) send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b0);                       // tenth byte bit 0 only: most negative
    for (int i = 0; i < 9; i++) send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b1);                       // overflow beats truncation

    run_phase(KIND_LONG,  LIMIT_RESET,     240, 1'b0, 1'b0);
    run_phase(KIND_INT,   $urandom,        240, 1'b0, 1'b1);
    run_phase(KIND_INDEX, 32'd0,           180, 1'b0, 1'b0);   // empty index range
    run_phase(KIND_INDEX, 32'hFFFF_FFFF,   240, 1'b0, 1'b0);
    run_phase(KIND_SPARE, $urandom,        240, 1'b1, 1'b0);
    run_phase(KIND_INDEX, $urandom_range(1, 300), 240, 1'b0, 1'b0);
    run_phase(KIND_INT,   32'd1,           240, 1'b0, 1'b0);
    run_phase(KIND_INDEX, $urandom,        240, 1'b0, 1'b0);

    drain_results();
    repeat (2 * SETTLE) @(negedge clk);
    if (board.errors == 0) begin
      $display("** zigzag_varint_stream_decoder_core: PASSED **");
    end else begin
      $display("** zigzag_varint_stream_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
